// ===== rtl/tcga_pkg.sv =====
// Shared types and constants for the target cluster greedy assigner.
// Holds the input and result transaction structs and a small helper.
// No dependencies.
`timescale 1ns / 1ps

package tcga_pkg;

  localparam int NumAgents = 3;
  localparam int AgentIdW  = 2;
  localparam int CoordW    = 24;
  localparam int GateW     = 23;
  localparam logic [GateW-1:0] GateReset = 23'd512;

  localparam logic ModeDetect = 1'b0;
  localparam logic ModeAgent  = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [AgentIdW-1:0]      agent_index;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [AgentIdW-1:0]      agent_id;
    logic [1:0]               target_id;
    logic signed [CoordW-1:0] way_x;
    logic signed [CoordW-1:0] way_y;
    logic signed [CoordW-1:0] way_z;
    logic                     last;
  } out_t;

  // Magnitude of a 25-bit two's complement difference, as unsigned.
  function automatic logic [CoordW:0] abs25(input logic [CoordW:0] v);
    logic [CoordW:0] r;
    r = v[CoordW] ? (~v + 25'd1) : v;
    return r;
  endfunction

endpackage

// ===== rtl/tcga_div.sv =====
// Serial restoring divider: signed sum over unsigned non-zero count,
// truncated toward zero, one quotient bit per cycle. Uses tcga_pkg.
`timescale 1ns / 1ps

module tcga_div #(
  parameter int SUMW = 40,
  parameter int CW   = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SUMW-1:0] dividend_i,
  input  logic [CW-1:0]          divisor_i,
  output logic                   done_o,
  output logic signed [tcga_pkg::CoordW-1:0] quot_o
);
  import tcga_pkg::*;

  localparam int CntW = $clog2(SUMW + 1);

  logic            busy_q, done_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [CW-1:0]   rem_q;
  logic [SUMW-1:0] quo_q;
  logic [CW:0]     trial, diff;
  logic            ge;
  logic [SUMW-1:0] mag;
  logic [CoordW-1:0] qlow;

  assign trial = {rem_q, quo_q[SUMW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};
  assign mag   = dividend_i[SUMW-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign qlow  = quo_q[CoordW-1:0];
  assign quot_o = neg_q ? (~qlow + 1'b1) : qlow;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(SUMW);
        rem_q  <= '0;
        quo_q  <= mag;
        neg_q  <= dividend_i[SUMW-1];
      end else if (busy_q) begin
        rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
        quo_q <= {quo_q[SUMW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/target_cluster_greedy_assigner.sv =====
// Top level of the target cluster greedy assigner: slot state, sequencer,
// shared squaring multiplier and output register. Uses tcga_pkg, tcga_div.
`timescale 1ns / 1ps

// Usage
// The input channel carries one transaction per detection or agent position
// update (in_valid_i / in_ready_o / in_data_i). An agent update is stored as
// soon as it is accepted. A detection is compared against each slot in turn,
// one slot per cycle; when it joins a slot the new means are recomputed by a
// single serial divider, x then y, at one quotient bit per cycle over the full
// sum width.
// Once every slot is occupied a greedy assignment follows: for each of the
// three agents every free slot passes through an x term and a y term on the
// shared squaring multiplier and a compare, then the waypoint is loaded.
// Each waypoint is presented on the output channel and held until the
// receiver takes it; while the receiver stalls, the sequencer simply waits.
// The block accepts no new transaction until the previous one is finished.
// Reset empties all slots, clears agent positions and sets the gate radius
// to 2.0 m; the gate register may be written at any idle cycle.
module target_cluster_greedy_assigner #(
  parameter int NUM_SLOTS  = 3,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tcga_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tcga_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [tcga_pkg::GateW-1:0]        cfg_data_i
);
  import tcga_pkg::*;

  localparam int SumW = CoordW + COUNT_BITS;
  localparam int SiW  = $clog2(NUM_SLOTS);
  localparam logic [SiW-1:0] LastSlot = SiW'(NUM_SLOTS - 1);
  localparam logic [AgentIdW-1:0] LastAgent = AgentIdW'(NumAgents - 1);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam int SqW = 2 * (CoordW + 1);

  typedef enum logic [3:0] {
    StIdle, StMatch, StDivX, StDivY, StCheck, StSqX, StSqY, StCmp, StFin, StOut
  } state_e;

  state_e state_q;

  // Slot and agent state
  logic signed [SumW-1:0]   sum_x_q  [NUM_SLOTS];
  logic signed [SumW-1:0]   sum_y_q  [NUM_SLOTS];
  logic signed [CoordW-1:0] z_q      [NUM_SLOTS];
  logic signed [CoordW-1:0] mean_x_q [NUM_SLOTS];
  logic signed [CoordW-1:0] mean_y_q [NUM_SLOTS];
  logic [COUNT_BITS-1:0]    count_q  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]     taken_q;
  logic signed [CoordW-1:0] agent_x_q [NumAgents];
  logic signed [CoordW-1:0] agent_y_q [NumAgents];
  logic [GateW-1:0]         gate_q;

  // Working registers
  logic signed [CoordW-1:0] x_q, y_q, zin_q;
  logic [SiW-1:0]           slot_q, best_q;
  logic [AgentIdW-1:0]      agent_q;
  logic                     found_q, div_run_q;
  logic [SqW-1:0]           sqx_q, sqy_q, bestd_q;
  logic signed [CoordW-1:0] bx_q, by_q, bz_q;
  out_t                     out_q;
  logic                     out_valid_q;

  // Gate distance of the current detection to slot slot_q.
  logic [CoordW:0]   gdx, gdy, adx, ady, mop;
  logic [CoordW+1:0] gate_dist;
  logic [SqW-1:0]    prod, sq_dist;
  logic              all_full;

  assign gdx = abs25({mean_x_q[slot_q][CoordW-1], mean_x_q[slot_q]} - {x_q[CoordW-1], x_q});
  assign gdy = abs25({mean_y_q[slot_q][CoordW-1], mean_y_q[slot_q]} - {y_q[CoordW-1], y_q});
  assign gate_dist = {1'b0, gdx} + {1'b0, gdy};

  // Agent to slot offsets feed the one shared squaring multiplier.
  assign adx = abs25({agent_x_q[agent_q][CoordW-1], agent_x_q[agent_q]}
                     - {mean_x_q[slot_q][CoordW-1], mean_x_q[slot_q]});
  assign ady = abs25({agent_y_q[agent_q][CoordW-1], agent_y_q[agent_q]}
                     - {mean_y_q[slot_q][CoordW-1], mean_y_q[slot_q]});
  assign mop     = (state_q == StSqY) ? ady : adx;
  assign prod    = mop * mop;
  assign sq_dist = sqx_q + sqy_q;

  always_comb begin
    all_full = 1'b1;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (count_q[k] == '0) all_full = 1'b0;
    end
  end

  // Shared divider: the dividend follows the phase of the mean update.
  logic                     div_start, div_done;
  logic signed [SumW-1:0]   div_num;
  logic signed [CoordW-1:0] div_quot;

  assign div_start = ((state_q == StDivX) || (state_q == StDivY)) && !div_run_q;
  assign div_num   = (state_q == StDivY) ? sum_y_q[slot_q] : sum_x_q[slot_q];

  tcga_div #(
    .SUMW(SumW),
    .CW  (COUNT_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (count_q[slot_q]),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      gate_q      <= GateReset;
      out_valid_q <= 1'b0;
      div_run_q   <= 1'b0;
      taken_q     <= '0;
      found_q     <= 1'b0;
      slot_q      <= '0;
      best_q      <= '0;
      agent_q     <= '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        sum_x_q[k]  <= '0;
        sum_y_q[k]  <= '0;
        z_q[k]      <= '0;
        mean_x_q[k] <= '0;
        mean_y_q[k] <= '0;
        count_q[k]  <= '0;
      end
      for (int k = 0; k < NumAgents; k++) begin
        agent_x_q[k] <= '0;
        agent_y_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) gate_q <= cfg_data_i;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            if (in_data_i.mode == ModeAgent) begin
              if (in_data_i.agent_index < AgentIdW'(NumAgents)) begin
                agent_x_q[in_data_i.agent_index] <= in_data_i.pos_x;
                agent_y_q[in_data_i.agent_index] <= in_data_i.pos_y;
              end
            end else begin
              x_q     <= in_data_i.pos_x;
              y_q     <= in_data_i.pos_y;
              zin_q   <= in_data_i.pos_z;
              slot_q  <= '0;
              state_q <= StMatch;
            end
          end
        end
        StMatch: begin
          if (count_q[slot_q] == '0) begin
            // Empty slot: the mean of a single point is the point itself.
            sum_x_q[slot_q]  <= SumW'(x_q);
            sum_y_q[slot_q]  <= SumW'(y_q);
            z_q[slot_q]      <= zin_q;
            mean_x_q[slot_q] <= x_q;
            mean_y_q[slot_q] <= y_q;
            count_q[slot_q]  <= COUNT_BITS'(1);
            state_q          <= StCheck;
          end else if (gate_dist < {3'b000, gate_q}) begin
            if (count_q[slot_q] != CountMax) begin
              sum_x_q[slot_q] <= sum_x_q[slot_q] + SumW'(x_q);
              sum_y_q[slot_q] <= sum_y_q[slot_q] + SumW'(y_q);
              z_q[slot_q]     <= zin_q;
              count_q[slot_q] <= count_q[slot_q] + 1'b1;
              state_q         <= StDivX;
            end else begin
              state_q <= StCheck;
            end
          end else if (slot_q == LastSlot) begin
            state_q <= StCheck;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
        StDivX: begin
          if (!div_run_q) begin
            div_run_q <= 1'b1;
          end else if (div_done) begin
            mean_x_q[slot_q] <= div_quot;
            div_run_q        <= 1'b0;
            state_q          <= StDivY;
          end
        end
        StDivY: begin
          if (!div_run_q) begin
            div_run_q <= 1'b1;
          end else if (div_done) begin
            mean_y_q[slot_q] <= div_quot;
            div_run_q        <= 1'b0;
            state_q          <= StCheck;
          end
        end
        StCheck: begin
          if (all_full) begin
            taken_q <= '0;
            agent_q <= '0;
            slot_q  <= '0;
            found_q <= 1'b0;
            best_q  <= '0;
            bx_q    <= mean_x_q[0];
            by_q    <= mean_y_q[0];
            bz_q    <= z_q[0];
            state_q <= StSqX;
          end else begin
            state_q <= StIdle;
          end
        end
        StSqX: begin
          if (taken_q[slot_q]) begin
            if (slot_q == LastSlot) begin
              state_q <= StFin;
            end else begin
              slot_q <= slot_q + 1'b1;
            end
          end else begin
            sqx_q   <= prod;
            state_q <= StSqY;
          end
        end
        StSqY: begin
          sqy_q   <= prod;
          state_q <= StCmp;
        end
        StCmp: begin
          // Strictly smaller wins, so the lower slot index keeps ties.
          if (!found_q || sq_dist < bestd_q) begin
            found_q <= 1'b1;
            bestd_q <= sq_dist;
            best_q  <= slot_q;
            bx_q    <= mean_x_q[slot_q];
            by_q    <= mean_y_q[slot_q];
            bz_q    <= z_q[slot_q];
          end
          if (slot_q == LastSlot) begin
            state_q <= StFin;
          end else begin
            slot_q  <= slot_q + 1'b1;
            state_q <= StSqX;
          end
        end
        StFin: begin
          if (found_q) taken_q[best_q] <= 1'b1;
          out_q.agent_id  <= agent_q;
          out_q.target_id <= 2'(best_q);
          out_q.way_x     <= bx_q;
          out_q.way_y     <= by_q;
          out_q.way_z     <= bz_q;
          out_q.last      <= (agent_q == LastAgent);
          out_valid_q     <= 1'b1;
          state_q         <= StOut;
        end
        StOut: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (agent_q == LastAgent) begin
              state_q <= StIdle;
            end else begin
              agent_q <= agent_q + 1'b1;
              slot_q  <= '0;
              found_q <= 1'b0;
              best_q  <= '0;
              bx_q    <= mean_x_q[0];
              by_q    <= mean_y_q[0];
              bz_q    <= z_q[0];
              state_q <= StSqX;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule
